>>> rtl/q2e_pkg.sv
// Shared types, constants and helpers for the quaternion to Euler angle pipeline.
// Holds the CORDIC arctangent table and the item fields passed between stages.
package q2e_pkg;

  localparam int TabLen = 24;
  localparam int AngW = 34;
  localparam int ValW = 34;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [ValW-1:0] val_t;

  function automatic ang_t atan_entry(input int idx);
    ang_t t;
    case (idx)
      0: t = 34'sd536870912;
      1: t = 34'sd316933405;
      2: t = 34'sd167458907;
      3: t = 34'sd85004756;
      4: t = 34'sd42667331;
      5: t = 34'sd21354465;
      6: t = 34'sd10679838;
      7: t = 34'sd5340245;
      8: t = 34'sd2670163;
      9: t = 34'sd1335086;
      10: t = 34'sd667544;
      11: t = 34'sd333772;
      12: t = 34'sd166886;
      13: t = 34'sd83443;
      14: t = 34'sd41721;
      15: t = 34'sd20860;
      16: t = 34'sd10430;
      17: t = 34'sd5215;
      18: t = 34'sd2607;
      19: t = 34'sd1303;
      20: t = 34'sd651;
      21: t = 34'sd325;
      22: t = 34'sd162;
      23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic lock;
    logic pos;
  } side_t;

endpackage

>>> rtl/quaternion_to_euler_angles.sv
// Quaternion (Q1.14) to yaw, pitch and roll binary angles, fully pipelined.
// One item per cycle unless the output stalls. Pipeline: 3 arithmetic stages,
// 29 square root stages, the CORDIC stages and 1 output stage.
// The whole pipeline advances only when the output register is free or taken.
// Reset (rst, synchronous) clears all valid bits and sets the threshold to 16382.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic signed [15:0] qw,
  input  logic signed [15:0] qx,
  input  logic signed [15:0] qy,
  input  logic signed [15:0] qz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] yaw,
  output logic signed [15:0] pitch,
  output logic signed [15:0] roll,
  output logic               gimbal_lock,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data
);
  import q2e_pkg::*;

  logic [14:0] thr;
  logic        en;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 15'd16382;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  assign en    = !out_valid || out_ready;
  assign ready = en;

  // Stage 1: all products.
  logic        v1;
  logic signed [31:0] pwx, pyz, pwy, pxz, pxy, pwz, pxx, pyy, pzz;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= valid;
    end
    if (en) begin
      pwx <= qw * qx;
      pyz <= qy * qz;
      pwy <= qw * qy;
      pxz <= qx * qz;
      pxy <= qx * qy;
      pwz <= qw * qz;
      pxx <= qx * qx;
      pyy <= qy * qy;
      pzz <= qz * qz;
    end
  end

  // Stage 2: sums, branch decision and clamp.
  localparam val_t Half = val_t'(34'sd1 <<< 27);
  localparam val_t One  = val_t'(34'sd1 <<< 28);
  val_t sp, mag, s_c, sm;
  logic lk;
  assign sp  = val_t'(2) * (val_t'(pwx) - val_t'(pyz));
  assign mag = (sp < 0) ? -sp : sp;
  assign lk  = mag >= val_t'({thr, 14'd0});
  assign s_c = (sp > One) ? One : ((sp < -One) ? -One : sp);
  assign sm  = (mag > One) ? One : mag;

  logic v2;
  side_t sd2;
  val_t s2, yy2, yx2, ry2, rx2;
  logic [28:0] sm2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      sd2.lock <= lk;
      sd2.pos  <= sp >= 0;
      s2  <= s_c;
      sm2 <= sm[28:0];
      if (lk) begin
        yy2 <= val_t'(pwy) - val_t'(pxz);
        yx2 <= Half - val_t'(pyy) - val_t'(pzz);
      end else begin
        yy2 <= val_t'(pxz) + val_t'(pwy);
        yx2 <= Half - val_t'(pxx) - val_t'(pyy);
      end
      ry2 <= val_t'(pxy) + val_t'(pwz);
      rx2 <= Half - val_t'(pxx) - val_t'(pzz);
    end
  end

  // Stage 3: square root argument from the clamped magnitude.
  logic v2q;
  side_t sd2q;
  val_t s2q, yy2q, yx2q, ry2q, rx2q;
  logic [56:0] sq2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2q <= 1'b0;
    end else if (en) begin
      v2q <= v2;
    end
    if (en) begin
      sd2q <= sd2;
      s2q  <= s2;
      yy2q <= yy2;
      yx2q <= yx2;
      ry2q <= ry2;
      rx2q <= rx2;
      sq2  <= (57'd1 << 56) - 57'(sm2) * 57'(sm2);
    end
  end

  localparam int SideW = 2 + 5 * ValW;
  logic             v3;
  logic [28:0]      root3;
  logic [SideW-1:0] side3;
  q2e_isqrt #(.SideW(SideW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2q), .in_val(sq2),
    .in_side({sd2q, s2q, yy2q, yx2q, ry2q, rx2q}),
    .out_valid(v3), .out_root(root3), .out_side(side3)
  );

  side_t sd3;
  val_t  s3, yy3, yx3, ry3, rx3;
  assign {sd3, s3, yy3, yx3, ry3, rx3} = side3;

  logic side_v;
  side_t sdc;
  side_t sdp [CORDIC_STAGES+1];
  always_comb begin
    sdp[0] = sd3;
  end
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) begin
        sdp[i+1] <= sdp[i];
      end
    end
  end
  // The CORDIC has min(CORDIC_STAGES, 24) + 1 stages; pad to match.
  localparam int CN = (CORDIC_STAGES > TabLen) ? TabLen : CORDIC_STAGES;
  side_t sd_last;
  always_ff @(posedge clk) begin
    if (en) begin
      sd_last <= sdp[CN];
    end
  end
  assign sdc    = sd_last;
  assign side_v = v3;

  logic vy, vp, vr;
  ang_t ay, ap, ar;
  q2e_cordic #(.Stages(CORDIC_STAGES)) u_yaw (
    .clk(clk), .rst(rst), .en(en), .in_valid(side_v),
    .in_y(yy3), .in_x(yx3), .out_valid(vy), .out_ang(ay)
  );
  q2e_cordic #(.Stages(CORDIC_STAGES)) u_pitch (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .in_y(s3), .in_x(val_t'({5'd0, root3})), .out_valid(vp), .out_ang(ap)
  );
  q2e_cordic #(.Stages(CORDIC_STAGES)) u_roll (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .in_y(ry3), .in_x(rx3), .out_valid(vr), .out_ang(ar)
  );

  ang_t by, bp, br;
  assign by = (ay + ang_t'(32768)) >>> 16;
  assign bp = (ap + ang_t'(32768)) >>> 16;
  assign br = (ar + ang_t'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vy & vp & vr;
    end
    if (en) begin
      yaw         <= by[15:0];
      gimbal_lock <= sdc.lock;
      if (sdc.lock) begin
        pitch <= sdc.pos ? 16'sd16384 : -16'sd16384;
        roll  <= '0;
      end else begin
        if (bp > ang_t'(16384)) begin
          pitch <= 16'sd16384;
        end else if (bp < -ang_t'(16384)) begin
          pitch <= -16'sd16384;
        end else begin
          pitch <= bp[15:0];
        end
        roll <= br[15:0];
      end
    end
  end
endmodule

>>> rtl/q2e_isqrt.sv
// Pipelined integer square root, one result bit per stage, with valid and stall.
// Does not use q2e_pkg; the side information carried alongside each item is a SideW-bit vector.
module q2e_isqrt #(
  parameter int SideW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [56:0]      in_val,
  input  logic [SideW-1:0] in_side,
  output logic             out_valid,
  output logic [28:0]      out_root,
  output logic [SideW-1:0] out_side
);
  localparam int Steps = 29;

  logic [Steps:0]            vld;
  logic [57:0]               rem  [Steps+1];
  logic [57:0]               res  [Steps+1];
  logic [SideW-1:0]          side [Steps+1];

  always_comb begin
    vld[0]  = in_valid;
    rem[0]  = {1'b0, in_val};
    res[0]  = '0;
    side[0] = in_side;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_st
    localparam logic [57:0] Bit = 58'd1 << (56 - 2 * i);
    logic [57:0] trial;
    assign trial = res[i] + Bit;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        side[i+1] <= side[i];
        if (rem[i] >= trial) begin
          rem[i+1] <= rem[i] - trial;
          res[i+1] <= (res[i] >> 1) + Bit;
        end else begin
          rem[i+1] <= rem[i];
          res[i+1] <= res[i] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[Steps];
  assign out_root  = res[Steps][28:0];
  assign out_side  = side[Steps];
endmodule

>>> rtl/q2e_cordic.sv
// Pipelined vectoring CORDIC giving atan2 in units where 2^31 equals pi.
// Depends on q2e_pkg for the arctangent table and value widths.
module q2e_cordic #(
  parameter int Stages = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  q2e_pkg::val_t   in_y,
  input  q2e_pkg::val_t   in_x,
  output logic            out_valid,
  output q2e_pkg::ang_t   out_ang
);
  import q2e_pkg::*;

  localparam int N = (Stages > TabLen) ? TabLen : Stages;

  logic [N:0] vld;
  val_t       xs [N+1];
  val_t       ys [N+1];
  ang_t       as [N+1];
  logic       zr [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      zr[0] <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        if (in_y >= 0) begin
          xs[0] <= in_y;
          ys[0] <= -in_x;
          as[0] <= ang_t'(34'sd1 <<< 30);
        end else begin
          xs[0] <= -in_y;
          ys[0] <= in_x;
          as[0] <= -ang_t'(34'sd1 <<< 30);
        end
      end else begin
        xs[0] <= in_x;
        ys[0] <= in_y;
        as[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        zr[i+1] <= zr[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          as[i+1] <= as[i] + atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          as[i+1] <= as[i] - atan_entry(i);
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_ang   = zr[N] ? '0 : as[N];
endmodule
